FILE: rtl/core/rsb_pkg.sv
`timescale 1ns / 1ps

package rsb_pkg;

   localparam int SCREEN_W    = 128;
   localparam int SCREEN_H    = 96;
   localparam int ANGLE_STEPS = 24;
   localparam int ROW_BYTES   = (SCREEN_W + 1) / 2;
   localparam int STORE_SIZE  = ROW_BYTES * SCREEN_H;
   localparam int ADDR_W      = $clog2(STORE_SIZE);
   localparam int X_W         = $clog2(SCREEN_W);
   localparam int Y_W         = $clog2(SCREEN_H);
   localparam int STEP_W      = 5;
   localparam int TAB_DIV     = 8;
   localparam int ZOOM_DIV    = 128;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [1:0] OP_ROTATE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_DIM    = 2'd3;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_W    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_H    = 3'd5;

   localparam logic signed [7:0] SIN_TAB [ANGLE_STEPS] = '{
      8'sd0, 8'sd33, 8'sd64, 8'sd91, 8'sd111, 8'sd124, 8'sd127, 8'sd124,
      8'sd111, 8'sd91, 8'sd64, 8'sd33, 8'sd0, -8'sd33, -8'sd64, -8'sd91,
      -8'sd111, -8'sd124, -8'sd127, -8'sd124, -8'sd111, -8'sd91, -8'sd64, -8'sd33};

   localparam logic signed [7:0] COS_TAB [ANGLE_STEPS] = '{
      8'sd127, 8'sd124, 8'sd111, 8'sd91, 8'sd64, 8'sd33, 8'sd0, -8'sd33,
      -8'sd64, -8'sd91, -8'sd111, -8'sd124, -8'sd127, -8'sd124, -8'sd111, -8'sd91,
      -8'sd64, -8'sd33, 8'sd0, 8'sd33, 8'sd64, 8'sd91, 8'sd111, 8'sd124};

   // v*6/15 per nibble
   localparam logic [3:0] DIM_LUT [16] = '{
      4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2,
      4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6};

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic signed [8:0] zoom;
      logic signed [7:0] org_x;
      logic signed [7:0] org_y;
      logic [7:0]        img_w;
      logic [7:0]        img_h;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        op;
      logic              last;
      logic [3:0]        nib;
      logic [ADDR_W-1:0] raddr;
   } tok_type;

   typedef struct packed {
      logic [1:0]        op;
      logic              hit;
      logic [ADDR_W-1:0] addr;
      logic              odd;
      logic [3:0]        nib;
      logic              last;
      logic [1:0]        drawn;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } bst_type;

endpackage

FILE: rtl/core/rsb_queue.sv
`timescale 1ns / 1ps

module rsb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rsb_pkg::cmd_type          push_data,
   input  logic                      pop,
   output rsb_pkg::cmd_type          pop_data,
   output logic                      not_empty,
   output logic [rsb_pkg::QCNT_W-1:0] count
);

   rsb_pkg::cmd_type entry_ff [rsb_pkg::QDEPTH];
   logic [rsb_pkg::QPTR_W-1:0] wptr_ff, wptr_in;
   logic [rsb_pkg::QPTR_W-1:0] rptr_ff, rptr_in;
   logic [rsb_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = push ? rsb_pkg::QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = pop  ? rsb_pkg::QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = rsb_pkg::QCNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = rsb_pkg::QCNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data  = entry_ff[rptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

endmodule

FILE: rtl/core/rsb_front.sv
`timescale 1ns / 1ps

module rsb_front (
   input  logic                       clock,
   input  logic                       reset,
   input  rsb_pkg::cfg_type           cfg,
   input  rsb_pkg::bst_type           bst,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [1:0]                 req_op,
   input  logic [6:0]                 req_col,
   input  logic [7:0]                 req_row,
   input  logic [7:0]                 req_pair,
   input  logic [rsb_pkg::ADDR_W-1:0] req_addr,
   input  logic [rsb_pkg::QCNT_W-1:0] q_count,
   output logic                       q_push,
   output rsb_pkg::cmd_type           q_data
);

   // item hold register
   logic                       hold_v_ff, hold_v_in;
   logic                       k_ff, k_in;
   logic [1:0]                 op_ff;
   logic [6:0]                 col_ff;
   logic [7:0]                 row_ff;
   logic [7:0]                 pair_ff;
   logic [rsb_pkg::ADDR_W-1:0] addr_ff;

   // pixel pipeline
   logic                       p1v_ff, p2v_ff, p3v_ff;
   rsb_pkg::tok_type           tok1_ff, tok2_ff, tok3_ff, tok_in;
   logic signed [9:0]          dx_ff, dy_ff, dx_in, dy_in;
   logic signed [4:0]          c_ff, s_ff, c_in, s_in;
   logic signed [13:0]         a_ff, b_ff, a_in, b_in;
   logic signed [14:0]         cdx, sdy, sdx, cdy;
   logic signed [21:0]         za_ff, zb_ff, za_in, zb_in;
   logic signed [14:0]         qa, qb;
   logic signed [16:0]         nx, ny;
   logic                       on0_ff, on0_in;

   logic [rsb_pkg::STEP_W-1:0] idx;
   logic [7:0]                 cx, cy;
   logic [3:0]                 in_use;
   logic                       accept, issue, issue_last, on, is_rot;
   logic [rsb_pkg::ADDR_W-1:0] pix_addr;

   assign cx = {1'b0, cfg.img_w[7:1]};
   assign cy = {1'b0, cfg.img_h[7:1]};

   // every token in flight owns a queue slot
   assign in_use = 4'(q_count) + 4'(p1v_ff) + 4'(p2v_ff) + 4'(p3v_ff);
   assign issue      = hold_v_ff && (in_use < 4'(rsb_pkg::QDEPTH));
   assign issue_last = (op_ff != rsb_pkg::OP_ROTATE) || k_ff;
   assign req_tready = !hold_v_ff && !bst.init_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hold_v_in = hold_v_ff;
      k_in      = k_ff;
      if (accept) begin
         hold_v_in = 1'b1;
         k_in      = 1'b0;
      end else if (issue) begin
         k_in = 1'b1;
         if (issue_last) begin
            hold_v_in = 1'b0;
         end
      end
   end

   // stage 1: centre offsets and table lookup
   always_comb begin
      idx = (cfg.step >= rsb_pkg::STEP_W'(rsb_pkg::ANGLE_STEPS)) ?
            rsb_pkg::STEP_W'(cfg.step - rsb_pkg::STEP_W'(rsb_pkg::ANGLE_STEPS)) : cfg.step;
      c_in  = 5'(rsb_pkg::COS_TAB[idx] / rsb_pkg::TAB_DIV);
      s_in  = 5'(rsb_pkg::SIN_TAB[idx] / rsb_pkg::TAB_DIV);
      dx_in = $signed({2'b00, col_ff, k_ff}) - $signed({2'b00, cx});
      dy_in = $signed({2'b00, row_ff}) - $signed({2'b00, cy});
      tok_in.op    = op_ff;
      tok_in.last  = issue_last;
      tok_in.nib   = k_ff ? pair_ff[3:0] : pair_ff[7:4];
      tok_in.raddr = addr_ff;
   end

   // stage 2: rotation
   always_comb begin
      cdx  = 15'(c_ff) * 15'(dx_ff);
      sdy  = 15'(s_ff) * 15'(dy_ff);
      sdx  = 15'(s_ff) * 15'(dx_ff);
      cdy  = 15'(c_ff) * 15'(dy_ff);
      a_in = 14'(cdx - sdy);
      b_in = 14'(sdx + cdy);
   end

   // stage 3: zoom
   assign za_in = 22'(cfg.zoom) * 22'(a_ff);
   assign zb_in = 22'(cfg.zoom) * 22'(b_ff);

   // stage 4: scale down, offset, clip, address
   always_comb begin
      qa = 15'(za_ff / rsb_pkg::ZOOM_DIV);
      qb = 15'(zb_ff / rsb_pkg::ZOOM_DIV);
      nx = $signed(17'(cx)) + 17'(qa) + 17'(cfg.org_x);
      ny = $signed(17'(cy)) + 17'(qb) + 17'(cfg.org_y);
      on = (nx >= 0) && (nx < rsb_pkg::SCREEN_W) && (ny >= 0) && (ny < rsb_pkg::SCREEN_H);
      pix_addr = rsb_pkg::ADDR_W'(ny[rsb_pkg::Y_W-1:0]) * rsb_pkg::ADDR_W'(rsb_pkg::ROW_BYTES)
               + rsb_pkg::ADDR_W'(nx[rsb_pkg::X_W-1:1]);
      is_rot = (tok3_ff.op == rsb_pkg::OP_ROTATE);

      q_data.op    = tok3_ff.op;
      q_data.nib   = tok3_ff.nib;
      q_data.last  = tok3_ff.last;
      q_data.odd   = nx[0];
      q_data.addr  = is_rot ? pix_addr : tok3_ff.raddr;
      q_data.drawn = '0;
      q_data.hit   = 1'b0;
      if (is_rot) begin
         q_data.hit = on;
         if (tok3_ff.last) begin
            q_data.drawn = 2'({1'b0, on0_ff} + {1'b0, on});
         end
      end else if (tok3_ff.op == rsb_pkg::OP_READ) begin
         q_data.hit = (tok3_ff.raddr < rsb_pkg::ADDR_W'(rsb_pkg::STORE_SIZE));
      end
      on0_in = (p3v_ff && is_rot && !tok3_ff.last) ? on : on0_ff;
   end

   assign q_push = p3v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         k_ff      <= 1'b0;
         p1v_ff    <= 1'b0;
         p2v_ff    <= 1'b0;
         p3v_ff    <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         k_ff      <= k_in;
         p1v_ff    <= issue;
         p2v_ff    <= p1v_ff;
         p3v_ff    <= p2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         col_ff  <= req_col;
         row_ff  <= req_row;
         pair_ff <= req_pair;
         addr_ff <= req_addr;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      c_ff    <= c_in;
      s_ff    <= s_in;
      tok1_ff <= tok_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      tok2_ff <= tok1_ff;
      za_ff   <= za_in;
      zb_ff   <= zb_in;
      tok3_ff <= tok2_ff;
      on0_ff  <= on0_in;
   end

endmodule

FILE: rtl/core/rsb_back.sv
`timescale 1ns / 1ps

module rsb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  rsb_pkg::cmd_type q_data,
   output logic             q_pop,
   output rsb_pkg::bst_type bst,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_pixels_drawn
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_RMW  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_CLR  = 3'd4;
   localparam logic [2:0] ST_DIM  = 3'd5;

   localparam logic [rsb_pkg::ADDR_W-1:0] LAST_ADDR = rsb_pkg::ADDR_W'(rsb_pkg::STORE_SIZE - 1);
   localparam logic [rsb_pkg::ADDR_W-1:0] END_ADDR  = rsb_pkg::ADDR_W'(rsb_pkg::STORE_SIZE);

   logic [7:0] mem [rsb_pkg::STORE_SIZE];
   logic [7:0] rdata_ff;

   logic [2:0]                 st_ff, st_in;
   logic [rsb_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   logic [rsb_pkg::ADDR_W-1:0] widx_ff, widx_in;
   logic                       wpend_ff, wpend_in;
   rsb_pkg::cmd_type           cur_ff, cur_in;

   logic                       we;
   logic [rsb_pkg::ADDR_W-1:0] waddr, raddr;
   logic [7:0]                 wdata;

   logic       rv_ff, rv_in;
   logic [7:0] rd_ff;
   logic [1:0] dr_ff;
   logic       res;
   logic [7:0] res_rd;
   logic [1:0] res_dr;
   logic       out_free;

   assign out_free = !rv_ff || rsp_tready;

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      widx_in  = widx_ff;
      wpend_in = wpend_ff;
      cur_in   = cur_ff;
      we       = 1'b0;
      waddr    = cnt_ff;
      wdata    = '0;
      raddr    = q_data.addr;
      q_pop    = 1'b0;
      res      = 1'b0;
      res_rd   = '0;
      res_dr   = '0;
      unique case (st_ff)
         ST_INIT: begin
            we = 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in = '0;
               st_in  = ST_IDLE;
            end else begin
               cnt_in = rsb_pkg::ADDR_W'(cnt_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               unique case (q_data.op)
                  rsb_pkg::OP_ROTATE: begin
                     if (q_data.hit) begin
                        st_in = ST_RMW;
                     end else if (q_data.last) begin
                        res    = 1'b1;
                        res_dr = q_data.drawn;
                     end
                  end
                  rsb_pkg::OP_READ: begin
                     if (q_data.hit) begin
                        st_in = ST_RD;
                     end else begin
                        res = 1'b1;
                     end
                  end
                  rsb_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                     st_in  = ST_CLR;
                  end
                  rsb_pkg::OP_DIM: begin
                     cnt_in   = '0;
                     wpend_in = 1'b0;
                     st_in    = ST_DIM;
                  end
               endcase
            end
         end
         ST_RMW: begin
            we    = 1'b1;
            waddr = cur_ff.addr;
            wdata = cur_ff.odd ? {rdata_ff[7:4], cur_ff.nib} : {cur_ff.nib, rdata_ff[3:0]};
            if (cur_ff.last) begin
               res    = 1'b1;
               res_dr = cur_ff.drawn;
            end
            st_in = ST_IDLE;
         end
         ST_RD: begin
            res    = 1'b1;
            res_rd = rdata_ff;
            st_in  = ST_IDLE;
         end
         ST_CLR: begin
            we = 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               res   = 1'b1;
               st_in = ST_IDLE;
            end else begin
               cnt_in = rsb_pkg::ADDR_W'(cnt_ff + 1'b1);
            end
         end
         ST_DIM: begin
            // read one byte ahead of the write
            if (wpend_ff) begin
               we    = 1'b1;
               waddr = widx_ff;
               wdata = {rsb_pkg::DIM_LUT[rdata_ff[7:4]], rsb_pkg::DIM_LUT[rdata_ff[3:0]]};
            end
            if (cnt_ff != END_ADDR) begin
               raddr    = cnt_ff;
               widx_in  = cnt_ff;
               wpend_in = 1'b1;
               cnt_in   = rsb_pkg::ADDR_W'(cnt_ff + 1'b1);
            end else begin
               wpend_in = 1'b0;
               res      = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_INIT;
         end
      endcase
      rv_in = res ? 1'b1 : (rsp_tready ? 1'b0 : rv_ff);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_INIT;
         cnt_ff   <= '0;
         wpend_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         wpend_ff <= wpend_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff <= widx_in;
      cur_ff  <= cur_in;
      if (res) begin
         rd_ff <= res_rd;
         dr_ff <= res_dr;
      end
   end

   assign bst.init_busy    = (st_ff == ST_INIT);
   assign rsp_tvalid       = rv_ff;
   assign rsp_read_data    = rd_ff;
   assign rsp_pixels_drawn = dr_ff;

endmodule

FILE: rtl/core/rotate_scale_blit_framebuffer_core.sv
`timescale 1ns / 1ps

// Rotating, scaling blitter into a 128x96 framebuffer of 4-bit pixels, two per
// byte, even x in the high nibble. Opcode 0 maps a source byte's two pixels about
// the image centre and plots them, 1 reads a frame byte, 2 clears the frame and 3
// dims every nibble to v*6/15. Each item returns one result. A four-stage front
// pipeline maps pixels into a four-entry command queue; the back end owns the
// single-port-per-cycle frame memory (one write and one registered read per
// cycle), which sets the rate: a rotate item does one nibble read-modify-write
// per pixel that is not clipped, a read in range does one registered read, a
// clear writes every byte and a dim reads each byte one ahead of its write-back.
// After reset the memory is zeroed by a clearing pass during which req_tready stays low.
// Configuration writes are taken at any time and must only be made while idle.

module rotate_scale_blit_framebuffer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // src_col, src_row, pixel_pair, read_addr
   input  logic [1:0]                    req_tuser,  // opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // read_data, pixels_drawn
   input  logic                          csr_wr_en,
   input  logic [rsb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [8:0]                    csr_wdata
);

   rsb_pkg::cfg_type           cfg_ff, cfg_in;
   rsb_pkg::bst_type           bst;
   rsb_pkg::cmd_type           push_data, pop_data;
   logic                       q_push, q_pop, q_valid;
   logic [rsb_pkg::QCNT_W-1:0] q_count;
   logic [7:0]                 read_data;
   logic [1:0]                 pixels_drawn;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rsb_pkg::CSR_ROT_STEP: cfg_in.step  = csr_wdata[rsb_pkg::STEP_W-1:0];
            rsb_pkg::CSR_ZOOM:     cfg_in.zoom  = $signed(csr_wdata);
            rsb_pkg::CSR_ORIGIN_X: cfg_in.org_x = $signed(csr_wdata[7:0]);
            rsb_pkg::CSR_ORIGIN_Y: cfg_in.org_y = $signed(csr_wdata[7:0]);
            rsb_pkg::CSR_IMG_W:    cfg_in.img_w = csr_wdata[7:0];
            rsb_pkg::CSR_IMG_H:    cfg_in.img_h = csr_wdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step  <= '0;
         cfg_ff.zoom  <= 9'sd8;
         cfg_ff.org_x <= '0;
         cfg_ff.org_y <= '0;
         cfg_ff.img_w <= '0;
         cfg_ff.img_h <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .bst        (bst),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_col    (req_tdata[6:0]),
      .req_row    (req_tdata[14:7]),
      .req_pair   (req_tdata[22:15]),
      .req_addr   (req_tdata[35:23]),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_data     (push_data)
   );

   rsb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_valid),
      .count     (q_count)
   );

   rsb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (pop_data),
      .q_pop            (q_pop),
      .bst              (bst),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_read_data    (read_data),
      .rsp_pixels_drawn (pixels_drawn)
   );

   assign rsp_tdata = {6'b000000, pixels_drawn, read_data};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_count <= rsb_pkg::QCNT_W'(rsb_pkg::QDEPTH)) && !(q_push && !q_pop &&
      q_count == rsb_pkg::QCNT_W'(rsb_pkg::QDEPTH)))
      else $error("command queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty command queue");

   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      bst.init_busy |-> !req_tready && !rsp_tvalid)
      else $error("item traffic during clearing pass");

   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pixels_drawn != 2'd3) && ((pixels_drawn == 2'd0) || (read_data == 8'd0)))
      else $error("malformed result");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import rsb_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 16;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] pixels_drawn;
   } blit_result_type;

   class frame_predictor;
      logic [7:0]      frame_bytes [STORE_SIZE];
      int              rot_step, zoom_v, org_x, org_y, img_w, img_h;
      blit_result_type pending_results [$];
      int              recent_addr [$];
      int              mismatches;

      function new();
         clear_frame();
         rot_step   = 0;
         zoom_v     = 8;
         org_x      = 0;
         org_y      = 0;
         img_w      = 0;
         img_h      = 0;
         mismatches = 0;
      endfunction

      function void clear_frame();
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [8:0] value);
         case (idx)
            CSR_ROT_STEP: rot_step = int'(value[4:0]);
            CSR_ZOOM:     zoom_v   = $signed(value[8:0]);
            CSR_ORIGIN_X: org_x    = $signed(value[7:0]);
            CSR_ORIGIN_Y: org_y    = $signed(value[7:0]);
            CSR_IMG_W:    img_w    = int'(value[7:0]);
            CSR_IMG_H:    img_h    = int'(value[7:0]);
            default: ;
         endcase
      endfunction

      function int plot_nibble(int x, int y, logic [3:0] nib);
         int addr;
         if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return 0;
         addr = y * ROW_BYTES + x / 2;
         if (addr >= STORE_SIZE) return 0;
         if (x % 2 == 0) frame_bytes[addr][7:4] = nib;
         else frame_bytes[addr][3:0] = nib;
         recent_addr.push_back(addr);
         if (recent_addr.size() > 32) void'(recent_addr.pop_front());
         return 1;
      endfunction

      function void absorb_item(logic [1:0] op, logic [6:0] col, logic [7:0] row,
                                logic [7:0] pair, logic [12:0] raddr);
         blit_result_type res;
         int idx, c, s, cx, cy, dx, dy, nx, ny, drawn;
         res.read_data    = 8'h00;
         res.pixels_drawn = 2'd0;
         case (op)
            OP_ROTATE: begin
               idx   = rot_step % ANGLE_STEPS;
               c     = int'(COS_TAB[idx]) / TAB_DIV;
               s     = int'(SIN_TAB[idx]) / TAB_DIV;
               cx    = img_w / 2;
               cy    = img_h / 2;
               dy    = int'(row) - cy;
               drawn = 0;
               for (int k = 0; k < 2; k++) begin
                  dx = int'(col) * 2 + k - cx;
                  nx = cx + (zoom_v * (c * dx - s * dy)) / ZOOM_DIV;
                  ny = cy + (zoom_v * (s * dx + c * dy)) / ZOOM_DIV;
                  drawn += plot_nibble(nx + org_x, ny + org_y,
                                       (k == 0) ? pair[7:4] : pair[3:0]);
               end
               res.pixels_drawn = 2'(drawn);
            end
            OP_READ: begin
               if (int'(raddr) < STORE_SIZE) res.read_data = frame_bytes[raddr];
            end
            OP_CLEAR: clear_frame();
            default: begin
               foreach (frame_bytes[i]) begin
                  frame_bytes[i][7:4] = 4'(int'(frame_bytes[i][7:4]) * 6 / 15);
                  frame_bytes[i][3:0] = 4'(int'(frame_bytes[i][3:0]) * 6 / 15);
               end
            end
         endcase
         pending_results.push_back(res);
      endfunction

      function void compare_result(logic [7:0] rd, logic [1:0] drawn);
         blit_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: read_data %0h pixels_drawn %0d", rd, drawn);
            return;
         end
         want = pending_results.pop_front();
         if (want.read_data !== rd || want.pixels_drawn !== drawn) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: read_data exp %0h got %0h, pixels_drawn exp %0d got %0d",
                        want.read_data, rd, want.pixels_drawn, drawn);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [39:0]          req_tdata;  // src_col, src_row, pixel_pair, read_addr
   logic [1:0]           req_tuser;  // opcode
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;  // read_data, pixels_drawn
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [8:0]           csr_wdata;

   frame_predictor frame_pred = new();
   bit             quiet      = 1'b0;
   int             cycle_count = 0;

   rotate_scale_blit_framebuffer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // absorb first so a same-edge result still finds its expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            frame_pred.absorb_item(req_tuser, req_tdata[6:0], req_tdata[14:7],
                                   req_tdata[22:15], req_tdata[35:23]);
         if (rsp_tvalid && rsp_tready)
            frame_pred.compare_result(rsp_tdata[7:0], rsp_tdata[9:8]);
      end
   end

   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic [1:0] op, logic [6:0] col, logic [7:0] row,
                            logic [7:0] pair, logic [12:0] raddr);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, raddr, pair, row, col};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (frame_pred.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[8:0];
      frame_pred.set_reg(idx, value[8:0]);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all(int step, int zoom, int ox, int oy, int w, int h);
      write_reg(CSR_ROT_STEP, step);
      write_reg(CSR_ZOOM, zoom);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_IMG_W, w);
      write_reg(CSR_IMG_H, h);
   endtask

   initial begin
      int          r;
      logic [1:0]  op;
      logic [6:0]  col;
      logic [7:0]  row, pair;
      logic [12:0] raddr;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ROTATE;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_ROT_STEP;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration, store edges
      send_item(OP_READ,   7'd0,   8'd0,   8'h00, 13'd0);
      send_item(OP_READ,   7'd0,   8'd0,   8'h00, 13'd6143);
      send_item(OP_READ,   7'd127, 8'd255, 8'hFF, 13'd6144);
      send_item(OP_READ,   7'd127, 8'd255, 8'hFF, 13'd8191);
      send_item(OP_ROTATE, 7'd0,   8'd0,   8'hF0, 13'd0);
      send_item(OP_ROTATE, 7'd127, 8'd255, 8'hFF, 13'h1FFF);
      send_item(OP_ROTATE, 7'd5,   8'd7,   8'h3C, 13'd0);
      send_item(OP_READ,   7'd0,   8'd0,   8'h00, 13'd0);
      wait_drain();

      // zero zoom: both pixels fall on one nibble, wrapped angle
      write_all(31, 0, 0, 0, 20, 20);
      send_item(OP_ROTATE, 7'd3,   8'd4,   8'hA5, 13'd0);
      send_item(OP_READ,   7'd0,   8'd0,   8'h00, 13'd645);
      send_item(OP_ROTATE, 7'd0,   8'd0,   8'h5A, 13'd0);
      send_item(OP_DIM,    7'd0,   8'd0,   8'h00, 13'd0);
      send_item(OP_READ,   7'd0,   8'd0,   8'h00, 13'd645);
      send_item(OP_ROTATE, 7'd1,   8'd2,   8'hFF, 13'd0);
      send_item(OP_READ,   7'd0,   8'd0,   8'h00, 13'd645);
      send_item(OP_CLEAR,  7'd0,   8'd0,   8'h00, 13'd0);
      send_item(OP_READ,   7'd0,   8'd0,   8'h00, 13'd645);
      wait_drain();

      write_all(23, -256, -128, 127, 255, 255);
      send_item(OP_ROTATE, 7'd127, 8'd255, 8'hFF, 13'd0);
      send_item(OP_ROTATE, 7'd0,   8'd0,   8'h00, 13'd0);
      send_item(OP_ROTATE, 7'd64,  8'd128, 8'h81, 13'd0);
      wait_drain();
      write_all(0, 255, 127, -128, 0, 0);
      send_item(OP_ROTATE, 7'd0,   8'd0,   8'h3C, 13'd0);
      send_item(OP_ROTATE, 7'd0,   8'd8,   8'hC3, 13'd0);
      wait_drain();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7) quiet = 1'b1;
         if (phase == 1) write_all(31, 255, 127, 127, 255, 255);
         else if (phase == 2) write_all(0, -256, -128, -128, 0, 0);
         else
            write_all($urandom_range(0, 31),
                      ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 511)) - 256
                                                  : int'($urandom_range(0, 48)) - 24,
                      ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 255)) - 128
                                                  : int'($urandom_range(0, 64)) - 16,
                      ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 255)) - 128
                                                  : int'($urandom_range(0, 48)) - 16,
                      $urandom_range(0, 255), $urandom_range(0, 255));
         for (int i = 0; i < 175; i++) begin
            col   = 7'($urandom());
            row   = 8'($urandom());
            pair  = 8'($urandom());
            raddr = 13'($urandom());
            r     = $urandom_range(0, 199);
            if (r < 2) op = OP_CLEAR;
            else if (r < 4) op = OP_DIM;
            else if (r < 70) op = OP_READ;
            else op = OP_ROTATE;
            if (op == OP_ROTATE && $urandom_range(0, 3) != 0) begin
               col = 7'($urandom_range(0, frame_pred.img_w / 2));
               row = 8'($urandom_range(0, frame_pred.img_h));
            end
            if (op == OP_READ) begin
               if (frame_pred.recent_addr.size() != 0 && $urandom_range(0, 1) == 0)
                  raddr = 13'(frame_pred.recent_addr[
                             $urandom_range(0, frame_pred.recent_addr.size() - 1)]);
               else if ($urandom_range(0, 7) == 0)
                  raddr = 13'($urandom_range(STORE_SIZE, 8191));
               else
                  raddr = 13'($urandom_range(0, STORE_SIZE - 1));
            end
            if (!quiet && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 6));
            send_item(op, col, row, pair, raddr);
         end
         wait_drain();
      end

      if (frame_pred.mismatches == 0 && frame_pred.pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
